FILE: rtl/core/mfba_pkg.sv
package mfba_pkg;

  localparam int ACT_W      = 1;
  localparam int VTX_W      = 6;
  localparam int ECAP_W     = 16;
  localparam int FLOW_W     = 22;
  localparam int NC_W       = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [ACT_W-1:0] ACT_WRITE = 1'b0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_SINK       = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BFS_INIT,
    ST_POP,
    ST_POP_WT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MIN_RD,
    ST_MIN_WT,
    ST_MIN_RES,
    ST_UPD_RD,
    ST_UPD_WT,
    ST_UPD_FWD,
    ST_UPD_REV,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/mfba_ifs.sv
interface mfba_item_if;
  import mfba_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [VTX_W-1:0]  from_vertex;
  logic [VTX_W-1:0]  to_vertex;
  logic [ECAP_W-1:0] edge_capacity;
  modport source (output valid, action, from_vertex, to_vertex, edge_capacity, input ready);
  modport sink (input valid, action, from_vertex, to_vertex, edge_capacity, output ready);
endinterface

interface mfba_result_if;
  import mfba_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] max_flow;
  modport source (output valid, max_flow, input ready);
  modport sink (input valid, max_flow, output ready);
endinterface

interface mfba_cfg_if;
  import mfba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/mfba_ram.sv
module mfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/max_flow_bfs_augment.sv
// Edmonds-Karp maximum flow engine over a dense capacity matrix.
// items channel: action 0 writes one edge capacity (from_vertex, to_vertex,
// edge_capacity), taken with no result; action 1 starts a run.
// results channel: one max_flow per run.
// cfg channel: node_count, source_node, sink_node; always ready, write only
// while the engine is idle.
// A run copies the capacities into the residual memory (read and write states
// per entry, min(node_count, MAX_NODES) squared entries), then repeats a
// breadth-first search (pop and wait per vertex popped, read and check per
// neighbour scanned) and a path augmentation (per path edge, read, wait and
// result states, then read, wait, forward and reverse states) until the sink
// is unreachable. All work goes through a single read and write port of the
// residual memory. A run with source equal to sink or an endpoint out of
// range goes straight to done. items.ready is low for the whole run. The
// result waits in an output register; a stalled receiver holds the next run
// at its end; capacity writes are still taken while idle. After reset the
// capacity memory is swept to zero, one entry per cycle, over all
// 2**(2*clog2(MAX_NODES)) entries (4096 by default), with items.ready low.
module max_flow_bfs_augment #(
  parameter int MAX_NODES = 64,
  parameter int CAP_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  mfba_item_if.sink     items,
  mfba_result_if.source results,
  mfba_cfg_if.sink      cfg
);
  import mfba_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int AW  = 2 * NW;
  localparam int RD  = 1 << AW;
  localparam int RW  = CAP_WIDTH + 1;
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = (NCW > NC_W) ? NCW : NC_W;

  state_t state, state_next;

  logic [NC_W-1:0]  node_count;
  logic [VTX_W-1:0] source_node;
  logic [VTX_W-1:0] sink_node;

  logic [AW-1:0]     clr_addr;
  logic [NW-1:0]     r, c, x, i, u, v, src, dst;
  logic [NW:0]       n, head, tail;
  logic [MAX_NODES-1:0] visited;
  logic [RW-1:0]     amount;
  logic [FLOW_W-1:0] total;
  logic              out_valid;
  logic [FLOW_W-1:0] out_data;

  logic                 cap_we;
  logic [AW-1:0]        cap_waddr;
  logic [CAP_WIDTH-1:0] cap_wdata, cap_rdata;
  logic                 res_we;
  logic [AW-1:0]        res_waddr, res_raddr;
  logic [RW-1:0]        res_wdata, res_rdata;
  logic                 par_we;
  logic [NW-1:0]        par_waddr, par_wdata, par_raddr, par_rdata;
  logic                 q_we;
  logic [NW-1:0]        q_waddr, q_wdata, q_rdata;

  logic          in_xfer, run_start, wr_start, trivial, hit, in_range;
  logic [EW-1:0] nlim;
  logic [NW-1:0] nm1;

  assign items.ready     = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign results.valid   = out_valid;
  assign results.max_flow = out_data;

  assign in_xfer   = items.valid && items.ready;
  assign run_start = in_xfer && (items.action == ACT_RUN);
  assign wr_start  = in_xfer && (items.action == ACT_WRITE);
  assign in_range  = (EW'(items.from_vertex) < EW'(MAX_NODES)) &&
                     (EW'(items.to_vertex) < EW'(MAX_NODES));
  assign nlim      = (EW'(node_count) > EW'(MAX_NODES)) ? EW'(MAX_NODES) : EW'(node_count);
  assign trivial   = (source_node == sink_node) || (EW'(source_node) >= nlim) ||
                     (EW'(sink_node) >= nlim);
  assign nm1       = NW'(n - 1'b1);
  assign hit       = (res_rdata != '0) && !visited[i];

  mfba_ram #(.WIDTH(CAP_WIDTH), .DEPTH(RD)) u_cap_ram (
    .clk, .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr({r, c}), .rdata(cap_rdata)
  );

  mfba_ram #(.WIDTH(RW), .DEPTH(RD)) u_res_ram (
    .clk, .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );

  mfba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_par_ram (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  mfba_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head[NW-1:0]), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NC_W'(64);
      source_node <= '0;
      sink_node   <= VTX_W'(63);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.addr))
        REG_NODE_COUNT: node_count  <= cfg.data[NC_W-1:0];
        REG_SOURCE:     source_node <= cfg.data[VTX_W-1:0];
        REG_SINK:       sink_node   <= cfg.data[VTX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_addr == AW'(RD - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (run_start) state_next = trivial ? ST_DONE : ST_COPY_RD;
      ST_COPY_RD:  state_next = ST_COPY_WR;
      ST_COPY_WR:  state_next = (r == nm1 && c == nm1) ? ST_BFS_INIT : ST_COPY_RD;
      ST_BFS_INIT: state_next = ST_POP;
      ST_POP:      state_next = (head == tail) ? ST_DONE : ST_POP_WT;
      ST_POP_WT:   state_next = ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (hit && i == dst) state_next = ST_MIN_RD;
        else if (i == nm1)   state_next = ST_POP;
        else                 state_next = ST_SCAN_RD;
      end
      ST_MIN_RD:   state_next = ST_MIN_WT;
      ST_MIN_WT:   state_next = ST_MIN_RES;
      ST_MIN_RES:  state_next = (v == src) ? ST_UPD_RD : ST_MIN_RD;
      ST_UPD_RD:   state_next = ST_UPD_WT;
      ST_UPD_WT:   state_next = ST_UPD_FWD;
      ST_UPD_FWD:  state_next = ST_UPD_REV;
      ST_UPD_REV:  state_next = (v == src) ? ST_BFS_INIT : ST_UPD_RD;
      ST_DONE:     if (!out_valid) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cap_we    = 1'b0;
    cap_waddr = clr_addr;
    cap_wdata = '0;
    res_we    = 1'b0;
    res_waddr = {r, c};
    res_wdata = RW'(cap_rdata);
    res_raddr = {x, i};
    par_we    = 1'b0;
    par_waddr = i;
    par_wdata = x;
    par_raddr = u;
    q_we      = 1'b0;
    q_waddr   = tail[NW-1:0];
    q_wdata   = i;
    unique case (state)
      ST_CLEAR: cap_we = 1'b1;
      ST_IDLE: begin
        cap_we    = wr_start && in_range;
        cap_waddr = {NW'(items.from_vertex), NW'(items.to_vertex)};
        cap_wdata = CAP_WIDTH'(items.edge_capacity);
      end
      ST_COPY_WR: res_we = 1'b1;
      ST_BFS_INIT: begin
        par_we    = 1'b1;
        par_waddr = src;
        par_wdata = src;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = src;
      end
      ST_SCAN_CHK: begin
        par_we = hit;
        q_we   = hit && (tail < (NW + 1)'(MAX_NODES));
      end
      ST_MIN_WT: res_raddr = {par_rdata, u};
      ST_UPD_WT: res_raddr = {par_rdata, u};
      ST_UPD_FWD: begin
        res_we    = 1'b1;
        res_waddr = {v, u};
        res_wdata = res_rdata - amount;
        res_raddr = {u, v};
      end
      ST_UPD_REV: begin
        res_we    = 1'b1;
        res_waddr = {u, v};
        res_wdata = res_rdata + amount;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_DONE && !out_valid) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n     <= (NW + 1)'(nlim);
        src   <= NW'(source_node);
        dst   <= NW'(sink_node);
        r     <= '0;
        c     <= '0;
        total <= '0;
      end
      ST_COPY_WR: begin
        c <= (c == nm1) ? '0 : c + 1'b1;
        if (c == nm1) r <= r + 1'b1;
      end
      ST_BFS_INIT: begin
        visited <= MAX_NODES'(1) << src;
        head    <= '0;
        tail    <= (NW + 1)'(1);
      end
      ST_POP: head <= head + 1'b1;
      ST_POP_WT: begin
        x <= q_rdata;
        i <= '0;
      end
      ST_SCAN_CHK: begin
        i <= i + 1'b1;
        if (hit) begin
          visited[i] <= 1'b1;
          tail       <= tail + 1'b1;
        end
        u      <= dst;
        amount <= '1;
      end
      ST_MIN_WT: v <= par_rdata;
      ST_MIN_RES: begin
        if (res_rdata < amount) amount <= res_rdata;
        u <= (v == src) ? dst : v;
      end
      ST_UPD_WT: v <= par_rdata;
      ST_UPD_REV: begin
        u <= v;
        if (v == src) total <= total + FLOW_W'(amount);
      end
      ST_DONE: if (!out_valid) out_data <= total;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/mfba_checker.sv
module mfba_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic [21:0] max_flow
);
  import mfba_pkg::*;

  // clear pass blocks items after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("items taken during clear pass");

  a_no_result_in_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_action == ACT_RUN) |=> !in_ready)
    else $error("engine ready right after run start");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated after transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(max_flow)))
    else $error("stalled result changed");

endmodule

bind max_flow_bfs_augment mfba_checker u_mfba_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(items.valid),
  .in_ready(items.ready),
  .in_action(items.action),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .max_flow(results.max_flow)
);
